// ===== rtl/core/tshs_pkg.sv =====
// ----------------------------------------------------------------------------
// tshs_pkg
// Shared types and constants of the three-state hysteresis path selector.
// ----------------------------------------------------------------------------
package tshs_pkg;

  // Width of the configuration data and of the threshold and count registers.
  localparam int CFG_DATA_W = 16;
  // Width of the configuration register index.
  localparam int CFG_IDX_W  = 3;
  // Width of the deviation sample, unsigned Q4.12.
  localparam int DEV_W      = 16;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;
  typedef logic [DEV_W-1:0]      dev_t;

  // Configuration register indexes.
  localparam cfg_idx_t REG_STABLE_THR  = 3'd0;
  localparam cfg_idx_t REG_BIG_THR     = 3'd1;
  localparam cfg_idx_t REG_SMALL_THR   = 3'd2;
  localparam cfg_idx_t REG_ENTER_CNT   = 3'd3;
  localparam cfg_idx_t REG_CONFIRM_CNT = 3'd4;
  localparam cfg_idx_t REG_RECOVER_CNT = 3'd5;

  // Reset values of the configuration registers.
  localparam cfg_data_t RST_STABLE_THR  = 16'd2048;
  localparam cfg_data_t RST_BIG_THR     = 16'd4096;
  localparam cfg_data_t RST_SMALL_THR   = 16'd819;
  localparam cfg_data_t RST_ENTER_CNT   = 16'd3;
  localparam cfg_data_t RST_CONFIRM_CNT = 16'd2;
  localparam cfg_data_t RST_RECOVER_CNT = 16'd3;

  typedef enum logic [1:0] {
    MODE_STABLE    = 2'd0,
    MODE_CANDIDATE = 2'd1,
    MODE_UNSTABLE  = 2'd2
  } mode_t;

endpackage

// ===== rtl/core/tshs_if.sv =====
// ----------------------------------------------------------------------------
// tshs_if
// Valid/ready channels of the hysteresis path selector: sample input,
// result output and configuration write.
// ----------------------------------------------------------------------------
interface tshs_in_if #(
  parameter int PATH_WIDTH = 16
);
  import tshs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [PATH_WIDTH-1:0] path_id;
  dev_t                  deviation;

  modport source (output valid, output path_id, output deviation, input ready);
  modport sink   (input valid, input path_id, input deviation, output ready);
endinterface

interface tshs_out_if #(
  parameter int PATH_WIDTH = 16
);
  import tshs_pkg::*;

  logic                  valid;
  logic                  ready;
  mode_t                 mode;
  logic [PATH_WIDTH-1:0] chosen_path;
  logic                  path_switched;

  modport source (output valid, output mode, output chosen_path, output path_switched,
                  input ready);
  modport sink   (input valid, input mode, input chosen_path, input path_switched,
                  output ready);
endinterface

interface tshs_cfg_if;
  import tshs_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/three_state_hysteresis_selector.sv =====
// ----------------------------------------------------------------------------
// three_state_hysteresis_selector
// Debounced three-state path selector: run counters of stable and unstable
// samples drive a Stable / Candidate / Unstable machine that latches a path.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Fields                              Word
//  in_ch    in   path_id, deviation                  one sample
//  out_ch   out  mode, chosen_path, path_switched    one result per sample
//  cfg_ch   in   index, data                         one register write
//
//  One word is accepted per cycle unless the output stalls; its result
//  enters the output register next cycle, in one compare-and-count pass.
//  Reset (rst_n low, synchronous) restores the register defaults, clears the
//  run counters, the selected path and the first-sample flag.
//  A stalled output blocks new input only while the output register is full
//  and not being taken. Configuration writes are always ready.
//
module three_state_hysteresis_selector #(
  parameter int COUNT_WIDTH = 16,
  parameter int PATH_WIDTH  = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  tshs_in_if.sink    in_ch,
  tshs_out_if.source out_ch,
  tshs_cfg_if.sink   cfg_ch
);
  import tshs_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [PATH_WIDTH-1:0]  path_t;

  // Configuration registers.
  cfg_data_t stable_thr_r, big_thr_r, floor_thr_r;
  cfg_data_t enter_cnt_r, confirm_cnt_r, recover_cnt_r;

  // Selector state.
  mode_t  mode_r, mode_nxt;
  count_t stable_run_r, stable_run_nxt;
  count_t unstable_run_r, unstable_run_nxt;
  path_t  chosen_path_r, chosen_path_nxt;
  logic   seen_first_r;
  logic   switched_nxt;

  // Output register.
  logic   out_valid_r;
  mode_t  out_mode_r;
  path_t  out_path_r;
  logic   out_switched_r;

  logic in_fire;
  logic below_stable, is_big, below_floor;
  logic [CMP_W-1:0] stable_run_x, unstable_run_x;
  logic [CMP_W-1:0] enter_x, confirm_x, recover_x;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.mode          = out_mode_r;
  assign out_ch.chosen_path   = out_path_r;
  assign out_ch.path_switched = out_switched_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_thr_r  <= RST_STABLE_THR;
      big_thr_r     <= RST_BIG_THR;
      floor_thr_r   <= RST_SMALL_THR;
      enter_cnt_r   <= RST_ENTER_CNT;
      confirm_cnt_r <= RST_CONFIRM_CNT;
      recover_cnt_r <= RST_RECOVER_CNT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_STABLE_THR:  stable_thr_r  <= cfg_ch.data;
        REG_BIG_THR:     big_thr_r     <= cfg_ch.data;
        REG_SMALL_THR:   floor_thr_r   <= cfg_ch.data;
        REG_ENTER_CNT:   enter_cnt_r   <= cfg_ch.data;
        REG_CONFIRM_CNT: confirm_cnt_r <= cfg_ch.data;
        REG_RECOVER_CNT: recover_cnt_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    below_stable = in_ch.deviation < stable_thr_r;
    is_big       = in_ch.deviation > big_thr_r;
    below_floor  = in_ch.deviation < floor_thr_r;

    // Each run counter saturates and is cleared by a sample of the other kind.
    if (below_stable) begin
      stable_run_nxt   = (stable_run_r == COUNT_MAX) ? COUNT_MAX : stable_run_r + 1'b1;
      unstable_run_nxt = '0;
    end else begin
      unstable_run_nxt = (unstable_run_r == COUNT_MAX) ? COUNT_MAX : unstable_run_r + 1'b1;
      stable_run_nxt   = '0;
    end

    stable_run_x   = CMP_W'(stable_run_nxt);
    unstable_run_x = CMP_W'(unstable_run_nxt);
    enter_x        = CMP_W'(enter_cnt_r);
    confirm_x      = CMP_W'(confirm_cnt_r);
    recover_x      = CMP_W'(recover_cnt_r);

    mode_nxt        = mode_r;
    chosen_path_nxt = chosen_path_r;
    switched_nxt    = 1'b0;

    if (!seen_first_r) begin
      chosen_path_nxt = in_ch.path_id;
      switched_nxt    = 1'b1;
    end

    case (mode_r)
      MODE_STABLE: begin
        if (!below_stable && unstable_run_x >= enter_x) mode_nxt = MODE_CANDIDATE;
      end
      MODE_CANDIDATE: begin
        if (is_big && unstable_run_x >= confirm_x) begin
          mode_nxt        = MODE_UNSTABLE;
          chosen_path_nxt = in_ch.path_id;
          switched_nxt    = 1'b1;
        end
        // The return to Stable is checked last and overrides the rule above.
        if (below_floor && stable_run_x >= confirm_x) mode_nxt = MODE_STABLE;
      end
      MODE_UNSTABLE: begin
        if (below_floor && stable_run_x >= recover_x) mode_nxt = MODE_CANDIDATE;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_STABLE;
      stable_run_r   <= '0;
      unstable_run_r <= '0;
      chosen_path_r  <= '0;
      seen_first_r   <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_fire) begin
        mode_r         <= mode_nxt;
        stable_run_r   <= stable_run_nxt;
        unstable_run_r <= unstable_run_nxt;
        chosen_path_r  <= chosen_path_nxt;
        seen_first_r   <= 1'b1;
        out_valid_r    <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_mode_r     <= mode_nxt;
      out_path_r     <= chosen_path_nxt;
      out_switched_r <= switched_nxt;
    end
  end

  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_ch.valid)
    else $error("accepted word produced no result");

  a_first_switches: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !seen_first_r) |=> out_ch.path_switched)
    else $error("first word did not latch the path");

  a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(stable_run_r != '0 && unstable_run_r != '0))
    else $error("both run counters are nonzero");

  a_mode_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |=> $stable(mode_r))
    else $error("mode changed without an accepted word");

  a_result_path_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.chosen_path == chosen_path_r))
    else $error("result path differs from the held path");

endmodule

// ===== tb/three_state_hysteresis_selector_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_state_hysteresis_selector_checker
// Watches the sample, result and configuration channels of the path selector.
// It keeps its own copy of the registers, run counters and mode. From each
// accepted sample word it works out the result word. Each result word that
// leaves the block is compared field by field with the oldest one still due.
// ----------------------------------------------------------------------------
module three_state_hysteresis_selector_checker
  import tshs_pkg::*;
#(
  parameter int COUNT_WIDTH = 16,
  parameter int PATH_WIDTH  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [PATH_WIDTH-1:0] in_path,
  input  dev_t                  in_dev,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  mode_t                 out_mode,
  input  logic [PATH_WIDTH-1:0] out_path,
  input  logic                  out_switched,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  cfg_idx_t              cfg_index,
  input  cfg_data_t             cfg_data,
  output int                    failures,
  output int                    outstanding
);

  localparam logic [COUNT_WIDTH-1:0] RUN_CEILING = '1;
  localparam int PRINT_LIMIT = 100;

  typedef struct {
    mode_t                 mode;
    logic [PATH_WIDTH-1:0] path;
    logic                  switched;
  } selector_result_t;

  selector_result_t due_results[$];

  cfg_data_t stable_thr, big_thr, floor_thr;
  cfg_data_t enter_cnt, confirm_cnt, recover_cnt;

  mode_t                  mode_now;
  logic [COUNT_WIDTH-1:0] calm_run;
  logic [COUNT_WIDTH-1:0] rough_run;
  logic [PATH_WIDTH-1:0]  held_path;
  logic                   primed;

  task automatic note_failure(input string what);
    failures = failures + 1;
    if (failures <= PRINT_LIMIT) begin
      $display("%0t ns mismatch: %s", $time, what);
    end
  endtask

  task automatic apply_write(input cfg_idx_t idx, input cfg_data_t val);
    case (idx)
      REG_STABLE_THR:  stable_thr = val;
      REG_BIG_THR:     big_thr = val;
      REG_SMALL_THR:   floor_thr = val;
      REG_ENTER_CNT:   enter_cnt = val;
      REG_CONFIRM_CNT: confirm_cnt = val;
      REG_RECOVER_CNT: recover_cnt = val;
      default: ;
    endcase
  endtask

  task automatic advance_selector(input logic [PATH_WIDTH-1:0] path, input dev_t dev,
                                  output selector_result_t res);
    logic calm, over, under;
    calm  = dev < stable_thr;
    over  = dev > big_thr;
    under = dev < floor_thr;
    res.switched = 1'b0;

    if (!primed) begin
      held_path = path;
      primed = 1'b1;
      res.switched = 1'b1;
    end

    // Each run count clears the other and holds at its ceiling.
    if (calm) begin
      if (calm_run != RUN_CEILING) calm_run = calm_run + 1'b1;
      rough_run = '0;
    end else begin
      if (rough_run != RUN_CEILING) rough_run = rough_run + 1'b1;
      calm_run = '0;
    end

    case (mode_now)
      MODE_STABLE: begin
        if (!calm && rough_run >= enter_cnt) mode_now = MODE_CANDIDATE;
      end
      MODE_CANDIDATE: begin
        if (over && rough_run >= confirm_cnt) begin
          mode_now = MODE_UNSTABLE;
          held_path = path;
          res.switched = 1'b1;
        end
        // When both rules fire, the return to Stable is applied last and wins.
        if (under && calm_run >= confirm_cnt) mode_now = MODE_STABLE;
      end
      MODE_UNSTABLE: begin
        if (under && calm_run >= recover_cnt) mode_now = MODE_CANDIDATE;
      end
      default: ;
    endcase

    res.mode = mode_now;
    res.path = held_path;
  endtask

  always @(posedge clk) begin : watch
    selector_result_t fresh;
    selector_result_t oldest;
    if (!rst_n) begin
      stable_thr  = RST_STABLE_THR;
      big_thr     = RST_BIG_THR;
      floor_thr   = RST_SMALL_THR;
      enter_cnt   = RST_ENTER_CNT;
      confirm_cnt = RST_CONFIRM_CNT;
      recover_cnt = RST_RECOVER_CNT;
      mode_now    = MODE_STABLE;
      calm_run    = '0;
      rough_run   = '0;
      held_path   = '0;
      primed      = 1'b0;
      failures    = 0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        advance_selector(in_path, in_dev, fresh);
        due_results.push_back(fresh);
      end
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          note_failure($sformatf("result word with none due: mode %0d path %h switched %b",
                                 out_mode, out_path, out_switched));
        end else begin
          oldest = due_results.pop_front();
          if (out_mode !== oldest.mode)
            note_failure($sformatf("mode %0d, expected %0d", out_mode, oldest.mode));
          if (out_path !== oldest.path)
            note_failure($sformatf("chosen_path %h, expected %h", out_path, oldest.path));
          if (out_switched !== oldest.switched)
            note_failure($sformatf("path_switched %b, expected %b",
                                   out_switched, oldest.switched));
        end
      end
    end
    outstanding = due_results.size();
  end

endmodule

// ===== tb/three_state_hysteresis_selector_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_state_hysteresis_selector_test
// Drives the hysteresis path selector with a directed walk through every
// state change and boundary, then random runs of calm and rough samples
// under several register settings. Samples idle and results stall at random.
// ----------------------------------------------------------------------------
module three_state_hysteresis_selector_test;
  import tshs_pkg::*;

  localparam int PATH_W         = 16;
  localparam int COUNT_W        = 16;
  localparam int NUM_REGS       = 6;
  localparam int PHASES         = 8;
  localparam int RANDOM_SAMPLES = 1850;
  localparam int CYCLE_LIMIT    = 3_000_000;

  // Indexes past the last register; writes to them must change nothing.
  localparam cfg_idx_t REG_UNUSED_A = 3'd6;
  localparam cfg_idx_t REG_UNUSED_B = 3'd7;

  typedef enum {DEV_CALM, DEV_QUIET, DEV_LOUD, DEV_BIG, DEV_BOUNDARY, DEV_NOISE} dev_class_t;

  logic clk;
  logic rst_n;
  int   failures;
  int   outstanding;
  int   cycles = 0;

  cfg_data_t regs_now [NUM_REGS];
  int        burst_left;
  int        burst_max;
  int        gap_max;

  tshs_in_if  #(.PATH_WIDTH(PATH_W)) in_ch ();
  tshs_out_if #(.PATH_WIDTH(PATH_W)) out_ch ();
  tshs_cfg_if                        cfg_ch ();

  three_state_hysteresis_selector #(
    .COUNT_WIDTH(COUNT_W),
    .PATH_WIDTH (PATH_W)
  ) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  three_state_hysteresis_selector_checker #(
    .COUNT_WIDTH(COUNT_W),
    .PATH_WIDTH (PATH_W)
  ) checker_inst (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_path     (in_ch.path_id),
    .in_dev      (in_ch.deviation),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_mode    (out_ch.mode),
    .out_path    (out_ch.chosen_path),
    .out_switched(out_ch.path_switched),
    .cfg_valid   (cfg_ch.valid),
    .cfg_ready   (cfg_ch.ready),
    .cfg_index   (cfg_ch.index),
    .cfg_data    (cfg_ch.data),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles = cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL three_state_hysteresis_selector");
      $finish;
    end
  end

  // Result side: the stall style is picked anew at random, from never stalling
  // to stalling about half the time.
  initial begin : result_side
    int stall_left;
    int style;
    int span;
    out_ch.ready = 1'b0;
    stall_left = 0;
    style = 0;
    span = 0;
    forever begin
      @(posedge clk);
      if (span == 0) begin
        style = $urandom_range(0, 3);
        span = $urandom_range(16, 200);
      end
      span = span - 1;
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        case (style)
          1: if ($urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 3);
          2: if ($urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 3);
          3: stall_left = $urandom_range(0, 1);
          default: ;
        endcase
      end
    end
  end

  task automatic send_sample(input logic [PATH_W-1:0] path, input dev_t dev);
    int gap;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      gap = $urandom_range(1, gap_max);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, burst_max);
    end
    in_ch.valid     <= 1'b1;
    in_ch.path_id   <= path;
    in_ch.deviation <= dev;
    do @(posedge clk); while (!in_ch.ready);
    burst_left = burst_left - 1;
  endtask

  // Stops the samples and waits until every result word has come out.
  task automatic drain;
    in_ch.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic offer_reg(input cfg_idx_t idx, input cfg_data_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic load_settings;
    int i;
    offer_reg(REG_UNUSED_A, cfg_data_t'($urandom));
    for (i = 0; i < NUM_REGS; i++) offer_reg(cfg_idx_t'(i), regs_now[i]);
    offer_reg(REG_UNUSED_B, cfg_data_t'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic dev_t pick_dev(input dev_class_t cls);
    dev_t calm_thr, big_thr, floor_thr, thr;
    int   pick;
    calm_thr  = regs_now[REG_STABLE_THR];
    big_thr   = regs_now[REG_BIG_THR];
    floor_thr = regs_now[REG_SMALL_THR];
    case (cls)
      DEV_CALM:
        return (floor_thr == 0) ? dev_t'(0) : dev_t'($urandom_range(0, int'(floor_thr) - 1));
      DEV_QUIET:
        return (calm_thr == 0) ? dev_t'(0) : dev_t'($urandom_range(0, int'(calm_thr) - 1));
      DEV_LOUD:
        return dev_t'($urandom_range(int'(calm_thr), 16'hFFFF));
      DEV_BIG:
        return (big_thr == 16'hFFFF) ? 16'hFFFF
                                     : dev_t'($urandom_range(int'(big_thr) + 1, 16'hFFFF));
      DEV_BOUNDARY: begin
        pick = $urandom_range(0, 8);
        thr = (pick < 3) ? calm_thr : (pick < 6) ? big_thr : floor_thr;
        return thr + dev_t'(pick % 3) - 16'd1;
      end
      default:
        return dev_t'($urandom);
    endcase
  endfunction

  // Runs of one kind of sample, up to two longer than the largest configured
  // count (capped at ten), mixed with some words of pure noise.
  task automatic random_stretch(input int count);
    int left;
    int shape;
    int len;
    int longest;
    dev_class_t cls;
    left = count;
    longest = int'(regs_now[REG_ENTER_CNT]);
    if (int'(regs_now[REG_CONFIRM_CNT]) > longest) longest = int'(regs_now[REG_CONFIRM_CNT]);
    if (int'(regs_now[REG_RECOVER_CNT]) > longest) longest = int'(regs_now[REG_RECOVER_CNT]);
    if (longest > 10) longest = 10;
    while (left > 0) begin
      shape = $urandom_range(0, 9);
      len = $urandom_range(1, longest + 2);
      case (shape)
        0, 1, 2: cls = DEV_CALM;
        3:       cls = DEV_QUIET;
        4, 5:    cls = DEV_BIG;
        6:       cls = DEV_LOUD;
        7:       cls = DEV_BOUNDARY;
        default: cls = DEV_NOISE;
      endcase
      while (len > 0 && left > 0) begin
        send_sample(PATH_W'($urandom), pick_dev(cls));
        len = len - 1;
        left = left - 1;
      end
    end
  endtask

  initial begin : stimulus
    int p;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.path_id = '0;
    in_ch.deviation = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_STABLE_THR;
    cfg_ch.data = '0;
    burst_left = 0;
    burst_max = 12;
    gap_max = 6;
    regs_now[REG_STABLE_THR]  = RST_STABLE_THR;
    regs_now[REG_BIG_THR]     = RST_BIG_THR;
    regs_now[REG_SMALL_THR]   = RST_SMALL_THR;
    regs_now[REG_ENTER_CNT]   = RST_ENTER_CNT;
    regs_now[REG_CONFIRM_CNT] = RST_CONFIRM_CNT;
    regs_now[REG_RECOVER_CNT] = RST_RECOVER_CNT;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings. The first word latches path zero although that is
    // already the held path, then the walk visits every mode and threshold edge.
    send_sample(16'h0000, 16'd0);
    send_sample(16'hFFFF, 16'd2047);
    send_sample(16'h1234, 16'd2048);
    send_sample(16'h5678, 16'd4096);
    send_sample(16'hA5A5, 16'hFFFF);
    send_sample(16'h0F0F, 16'd4096);
    send_sample(16'hF0F0, 16'd4097);
    send_sample(16'h0001, 16'd819);
    send_sample(16'h0002, 16'd818);
    send_sample(16'h0003, 16'd0);
    send_sample(16'h0004, 16'd0);
    drain();

    // With a zero confirm count and the small threshold above the big one,
    // both Candidate rules fire on one word.
    regs_now[REG_STABLE_THR]  = 16'h8000;
    regs_now[REG_BIG_THR]     = 16'h1000;
    regs_now[REG_SMALL_THR]   = 16'h9000;
    regs_now[REG_ENTER_CNT]   = 16'd0;
    regs_now[REG_CONFIRM_CNT] = 16'd0;
    regs_now[REG_RECOVER_CNT] = 16'd0;
    load_settings();
    send_sample(16'h00FF, 16'h8000);
    send_sample(16'hFF00, 16'h2000);
    send_sample(16'h0000, 16'h8000);
    send_sample(16'hFFFF, 16'h9000);
    send_sample(16'h1111, 16'h0000);
    send_sample(16'h2222, 16'h0000);
    drain();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          regs_now[REG_STABLE_THR]  = RST_STABLE_THR;
          regs_now[REG_BIG_THR]     = RST_BIG_THR;
          regs_now[REG_SMALL_THR]   = RST_SMALL_THR;
          regs_now[REG_ENTER_CNT]   = RST_ENTER_CNT;
          regs_now[REG_CONFIRM_CNT] = RST_CONFIRM_CNT;
          regs_now[REG_RECOVER_CNT] = RST_RECOVER_CNT;
        end
        1: foreach (regs_now[i]) regs_now[i] = '0;
        2: foreach (regs_now[i]) regs_now[i] = '1;
        3: begin
          regs_now[REG_STABLE_THR]  = 16'h8000;
          regs_now[REG_BIG_THR]     = 16'h1000;
          regs_now[REG_SMALL_THR]   = 16'h9000;
          regs_now[REG_ENTER_CNT]   = cfg_data_t'($urandom_range(0, 1));
          regs_now[REG_CONFIRM_CNT] = cfg_data_t'($urandom_range(0, 1));
          regs_now[REG_RECOVER_CNT] = cfg_data_t'($urandom_range(0, 1));
        end
        PHASES - 1: begin
          foreach (regs_now[i]) regs_now[i] = cfg_data_t'($urandom);
          regs_now[REG_ENTER_CNT]   = cfg_data_t'($urandom_range(0, 3));
          regs_now[REG_CONFIRM_CNT] = cfg_data_t'($urandom_range(0, 3));
          regs_now[REG_RECOVER_CNT] = cfg_data_t'($urandom_range(0, 3));
        end
        default: begin
          regs_now[REG_SMALL_THR]   = cfg_data_t'($urandom_range(0, 16'h3000));
          regs_now[REG_STABLE_THR]  = regs_now[REG_SMALL_THR]
                                      + cfg_data_t'($urandom_range(0, 16'h3000));
          regs_now[REG_BIG_THR]     = regs_now[REG_STABLE_THR]
                                      + cfg_data_t'($urandom_range(0, 16'h6000));
          regs_now[REG_ENTER_CNT]   = cfg_data_t'($urandom_range(0, 6));
          regs_now[REG_CONFIRM_CNT] = cfg_data_t'($urandom_range(0, 6));
          regs_now[REG_RECOVER_CNT] = cfg_data_t'($urandom_range(0, 6));
        end
      endcase
      load_settings();
      random_stretch(RANDOM_SAMPLES / PHASES);
      drain();
    end

    if (failures == 0) begin
      $display("PASS three_state_hysteresis_selector");
    end else begin
      $display("FAIL three_state_hysteresis_selector");
    end
    $finish;
  end

endmodule
